>>> rtl/gpma_pkg.sv
// Package for the gated position moving average.
// Field widths, register indexes, reset values and the sequencer state type.
`default_nettype none

package gpma_pkg;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int ACC_W  = 32;
  localparam int TIME_W = 63;
  localparam int CNT_W  = 10;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCURACY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READY_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE_MIN     = 2'd2;

  localparam logic [ACC_W-1:0] RESET_MAX_ACCURACY = 32'd5000;
  localparam logic [CNT_W-1:0] RESET_READY_MIN    = 10'd50;
  localparam logic [CNT_W-1:0] RESET_SAVE_MIN     = 10'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/gpma_if.sv
// Valid/ready channel interfaces for fixes in and averages out.
// Depends on gpma_pkg for field widths.
`default_nettype none

interface gpma_fix_if;
  logic                          valid;
  logic                          ready;
  logic                          fix_valid;
  logic [gpma_pkg::ACC_W-1:0]    accuracy_mm;
  logic [gpma_pkg::TIME_W-1:0]   rx_time_us;
  logic signed [gpma_pkg::LAT_W-1:0] lat_e7;
  logic signed [gpma_pkg::LON_W-1:0] lon_e7;

  modport source (output valid, fix_valid, accuracy_mm, rx_time_us, lat_e7, lon_e7,
                  input ready);
  modport sink   (input valid, fix_valid, accuracy_mm, rx_time_us, lat_e7, lon_e7,
                  output ready);
endinterface

interface gpma_avg_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [gpma_pkg::CNT_W-1:0]    sample_count;
  logic signed [gpma_pkg::LAT_W-1:0] mean_lat_e7;
  logic signed [gpma_pkg::LON_W-1:0] mean_lon_e7;
  logic                          ref_ready;
  logic                          save_ready;

  modport source (output valid, accepted, sample_count, mean_lat_e7, mean_lon_e7,
                  ref_ready, save_ready, input ready);
  modport sink   (input valid, accepted, sample_count, mean_lat_e7, mean_lon_e7,
                  ref_ready, save_ready, output ready);
endinterface

`default_nettype wire

>>> rtl/gpma_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none

module gpma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/gpma_sdiv.sv
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
// No dependencies.
`default_nettype none

module gpma_sdiv #(
  parameter int SW = 42,
  parameter int CW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [SW-1:0] dividend,
  input  wire logic [CW-1:0]        divisor,
  output logic                      done,
  output logic signed [SW-1:0]      quotient
);

  localparam int NW = $clog2(SW + 1);

  logic [SW-1:0] q;
  logic [CW-1:0] r;
  logic          neg;
  logic          busy;
  logic [NW-1:0] cnt;

  logic [CW:0] r_sh;
  logic [CW:0] diff;

  assign r_sh = {r, q[SW-1]};
  assign diff = r_sh - {1'b0, divisor};
  assign done = busy && (cnt == NW'(1));
  assign quotient = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= NW'(SW);
    end else if (busy) begin
      cnt  <= cnt - NW'(1);
      busy <= (cnt != NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SW-1];
      q   <= dividend[SW-1] ? -dividend : dividend;
      r   <= '0;
    end else if (busy) begin
      if (!diff[CW]) begin
        r <= diff[CW-1:0];
        q <= {q[SW-2:0], 1'b1};
      end else begin
        r <= r_sh[CW-1:0];
        q <= {q[SW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/gated_position_moving_average.sv
// Gated sliding-window moving average of position fixes.
// Fix requests arrive on fix_in, one result request per fix leaves on avg_out.
// A fix is taken into the window when fix_valid is set, accuracy_mm does not
// exceed the limit and rx_time_us differs from the last taken timestamp.
// The window of the last WINDOW lat/lon pairs lives in one RAM; running sums
// and a fill count are kept in registers. Both means come from bit-serial
// dividers that produce one quotient bit per cycle.
// A fix passes through the UPDATE, LOAD, DIV and DONE states before its result
// is registered. SW = 32 + clog2(WINDOW + 1) is the sum width.
// One fix is in work at a time, so fix_in takes no new fix until the
// sequencer is back in IDLE.
// The result sits in an output register; fix_in takes the next fix while it
// waits. If avg_out stalls, the next result holds in the sequencer until the
// register frees up.
// Reset (rst, synchronous) empties the window, clears the sums and the last
// timestamp and restores the register defaults. The user must write registers
// only while idle, via cfg_en/cfg_index/cfg_data; the block does not check.
// Depends on gpma_pkg, gpma_if, gpma_ram and gpma_sdiv.
`default_nettype none

module gated_position_moving_average #(
  parameter int WINDOW = 512
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_en,
  input  wire logic [gpma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gpma_pkg::CFG_W-1:0]     cfg_data,
  gpma_fix_if.sink                            fix_in,
  gpma_avg_if.source                          avg_out
);

  localparam int LAT_W = gpma_pkg::LAT_W;
  localparam int LON_W = gpma_pkg::LON_W;
  localparam int CNT_W = gpma_pkg::CNT_W;
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = 32 + CW;
  localparam int RW = LAT_W + LON_W;

  // configuration
  logic [gpma_pkg::ACC_W-1:0] max_accuracy;
  logic [CNT_W-1:0]           ready_min;
  logic [CNT_W-1:0]           save_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_accuracy <= gpma_pkg::RESET_MAX_ACCURACY;
      ready_min    <= gpma_pkg::RESET_READY_MIN;
      save_min     <= gpma_pkg::RESET_SAVE_MIN;
    end else if (cfg_en) begin
      unique case (cfg_index)
        gpma_pkg::REG_MAX_ACCURACY: max_accuracy <= cfg_data;
        gpma_pkg::REG_READY_MIN:    ready_min    <= cfg_data[CNT_W-1:0];
        gpma_pkg::REG_SAVE_MIN:     save_min     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  gpma_pkg::state_t state, state_next;

  logic                         take;
  logic signed [LAT_W-1:0]      lat;
  logic signed [LON_W-1:0]      lon;
  logic signed [SW-1:0]         lat_sum;
  logic signed [SW-1:0]         lon_sum;
  logic [CW-1:0]                fill_count;
  logic [AW-1:0]                write_slot;
  logic [gpma_pkg::TIME_W-1:0]  last_time;

  logic        out_valid;
  logic        out_accepted;
  logic [CNT_W-1:0] out_count;
  logic signed [LAT_W-1:0] out_lat;
  logic signed [LON_W-1:0] out_lon;
  logic        out_ref;
  logic        out_save;

  logic          accept_fix;
  logic          do_update;
  logic          div_start;
  logic          load_out;
  logic          take_now;
  logic          full;
  logic [RW-1:0] ring_rdata;
  logic          lat_done;
  logic          lon_done;
  logic signed [SW-1:0] lat_q;
  logic signed [SW-1:0] lon_q;
  logic signed [SW-1:0] lat_delta;
  logic signed [SW-1:0] lon_delta;
  logic [CW+CNT_W-1:0]  count_ext;

  assign take_now = fix_in.fix_valid && (fix_in.accuracy_mm <= max_accuracy)
                    && (fix_in.rx_time_us != last_time);
  assign full = (fill_count == CW'(WINDOW));
  assign count_ext = {{CNT_W{1'b0}}, fill_count};

  // new value minus the value leaving the window, if full
  always_comb begin
    lat_delta = {{(SW-LAT_W){lat[LAT_W-1]}}, lat};
    lon_delta = {{(SW-LON_W){lon[LON_W-1]}}, lon};
    if (full) begin
      lat_delta = lat_delta - {{(SW-LAT_W){ring_rdata[LAT_W-1]}}, ring_rdata[LAT_W-1:0]};
      lon_delta = lon_delta - {{(SW-LON_W){ring_rdata[RW-1]}}, ring_rdata[RW-1:LAT_W]};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gpma_pkg::ST_IDLE:   if (fix_in.valid) state_next = gpma_pkg::ST_UPDATE;
      gpma_pkg::ST_UPDATE: state_next = gpma_pkg::ST_LOAD;
      gpma_pkg::ST_LOAD:   state_next = gpma_pkg::ST_DIV;
      gpma_pkg::ST_DIV:    if (lat_done && lon_done) state_next = gpma_pkg::ST_DONE;
      gpma_pkg::ST_DONE:   if (!out_valid || avg_out.ready) state_next = gpma_pkg::ST_IDLE;
      default:             state_next = gpma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fix_in.ready = (state == gpma_pkg::ST_IDLE);
    do_update    = (state == gpma_pkg::ST_UPDATE) && take;
    div_start    = (state == gpma_pkg::ST_LOAD);
    load_out     = (state == gpma_pkg::ST_DONE) && (!out_valid || avg_out.ready);
  end

  assign accept_fix = fix_in.valid && fix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_fix) begin
      take <= take_now;
      lat  <= fix_in.lat_e7;
      lon  <= fix_in.lon_e7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_sum    <= '0;
      lon_sum    <= '0;
      fill_count <= '0;
      write_slot <= '0;
      last_time  <= '0;
    end else begin
      if (accept_fix && take_now) begin
        last_time <= fix_in.rx_time_us;
      end
      if (do_update) begin
        lat_sum <= lat_sum + lat_delta;
        lon_sum <= lon_sum + lon_delta;
        if (!full) begin
          fill_count <= fill_count + CW'(1);
        end
        write_slot <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + AW'(1);
      end
    end
  end

  gpma_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (do_update),
    .waddr (write_slot),
    .wdata ({lon, lat}),
    .raddr (write_slot),
    .rdata (ring_rdata)
  );

  gpma_sdiv #(
    .SW (SW),
    .CW (CW)
  ) u_lat_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lat_sum),
    .divisor  (fill_count),
    .done     (lat_done),
    .quotient (lat_q)
  );

  gpma_sdiv #(
    .SW (SW),
    .CW (CW)
  ) u_lon_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lon_sum),
    .divisor  (fill_count),
    .done     (lon_done),
    .quotient (lon_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (avg_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // empty window reads as a zero mean
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_accepted <= take;
      out_count    <= count_ext[CNT_W-1:0];
      out_lat      <= (fill_count == '0) ? '0 : lat_q[LAT_W-1:0];
      out_lon      <= (fill_count == '0) ? '0 : lon_q[LON_W-1:0];
      out_ref      <= count_ext >= {{CW{1'b0}}, ready_min};
      out_save     <= count_ext >= {{CW{1'b0}}, save_min};
    end
  end

  assign avg_out.valid        = out_valid;
  assign avg_out.accepted     = out_accepted;
  assign avg_out.sample_count = out_count;
  assign avg_out.mean_lat_e7  = out_lat;
  assign avg_out.mean_lon_e7  = out_lon;
  assign avg_out.ref_ready    = out_ref;
  assign avg_out.save_ready   = out_save;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for gated_position_moving_average: directed and random position fix
// requests, a local window average predictor and a field-by-field result check.
// Depends on gpma_pkg, gpma_if and the block's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int ACC_W     = gpma_pkg::ACC_W;
  localparam int TIME_W    = gpma_pkg::TIME_W;
  localparam int LAT_W     = gpma_pkg::LAT_W;
  localparam int LON_W     = gpma_pkg::LON_W;
  localparam int CNT_W     = gpma_pkg::CNT_W;
  localparam int CFG_W     = gpma_pkg::CFG_W;
  localparam int CFG_IDX_W = gpma_pkg::CFG_IDX_W;

  localparam int WIN = 512;
  localparam int LIMIT = 1500000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic                    fix_valid;
    logic [ACC_W-1:0]        accuracy_mm;
    logic [TIME_W-1:0]       rx_time_us;
    logic signed [LAT_W-1:0] lat_e7;
    logic signed [LON_W-1:0] lon_e7;
  } fix_t;

  typedef struct {
    logic                    accepted;
    logic [CNT_W-1:0]        sample_count;
    logic signed [LAT_W-1:0] mean_lat_e7;
    logic signed [LON_W-1:0] mean_lon_e7;
    logic                    ref_ready;
    logic                    save_ready;
  } avg_t;

  typedef enum {RX_OPEN, RX_COIN, RX_STALLS} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gpma_fix_if fix_ch ();
  gpma_avg_if avg_ch ();

  gated_position_moving_average #(.WINDOW(WIN)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fix_in    (fix_ch),
    .avg_out   (avg_ch)
  );

  // shadow of the block's registers and window
  logic [ACC_W-1:0] acc_limit = gpma_pkg::RESET_MAX_ACCURACY;
  logic [CNT_W-1:0] ready_min = gpma_pkg::RESET_READY_MIN;
  logic [CNT_W-1:0] save_min  = gpma_pkg::RESET_SAVE_MIN;
  longint           ring_lat [WIN];
  longint           ring_lon [WIN];
  longint           lat_total = 0;
  longint           lon_total = 0;
  logic [CNT_W-1:0] fill = '0;
  int               slot = 0;
  logic [63:0]      last_taken_time = '0;

  fix_t pending_fixes [$];
  avg_t averages_due [$];

  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_wraps = 0;
  int max_fill = 0;

  // generator state
  logic [TIME_W-1:0] prev_time = '0;
  int                base_lat = 0;
  longint            base_lon = 0;

  // handshake bookkeeping
  logic     took_fix = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       mode_timer = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic     rx_ready;
  fix_t     seen_fix;
  fix_t     next_fix;
  avg_t     want;
  avg_t     got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, averages_due.size());
      $display("tb failed");
      $finish;
    end
  end

  function automatic avg_t next_average(input fix_t f);
    avg_t   r;
    logic   take;
    longint q;
    take = f.fix_valid && (f.accuracy_mm <= acc_limit) &&
           ({1'b0, f.rx_time_us} != last_taken_time);
    if (take) begin
      if (fill >= WIN) begin
        lat_total -= ring_lat[slot];
        lon_total -= ring_lon[slot];
      end else begin
        fill++;
      end
      ring_lat[slot] = f.lat_e7;
      ring_lon[slot] = f.lon_e7;
      lat_total += f.lat_e7;
      lon_total += f.lon_e7;
      slot = (slot + 1) % WIN;
      last_taken_time = {1'b0, f.rx_time_us};
    end
    r.accepted = take;
    r.sample_count = fill;
    if (fill == 0) begin
      r.mean_lat_e7 = '0;
      r.mean_lon_e7 = '0;
    end else begin
      q = lat_total / longint'(fill);
      r.mean_lat_e7 = q[LAT_W-1:0];
      q = lon_total / longint'(fill);
      r.mean_lon_e7 = q[LON_W-1:0];
    end
    r.ref_ready = fill >= ready_min;
    r.save_ready = fill >= save_min;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // request acceptance, prediction and result checking
  always @(posedge clk) begin
    took_fix = !rst && fix_ch.valid && fix_ch.ready;
    if (took_fix) begin
      seen_fix.fix_valid = fix_ch.fix_valid;
      seen_fix.accuracy_mm = fix_ch.accuracy_mm;
      seen_fix.rx_time_us = fix_ch.rx_time_us;
      seen_fix.lat_e7 = fix_ch.lat_e7;
      seen_fix.lon_e7 = fix_ch.lon_e7;
      void'(pending_fixes.pop_front());
      want = next_average(seen_fix);
      averages_due.push_back(want);
      n_sent++;
      if (want.accepted) begin
        n_taken++;
        if (fill >= WIN && slot == 0) n_wraps++;
      end
      if (fill > max_fill) max_fill = fill;
    end
    if (!rst && avg_ch.valid && avg_ch.ready) begin
      got.accepted = avg_ch.accepted;
      got.sample_count = avg_ch.sample_count;
      got.mean_lat_e7 = avg_ch.mean_lat_e7;
      got.mean_lon_e7 = avg_ch.mean_lon_e7;
      got.ref_ready = avg_ch.ref_ready;
      got.save_ready = avg_ch.save_ready;
      if (averages_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none, actual count %0d",
                   $time, got.sample_count);
      end else begin
        want = averages_due.pop_front();
        n_checked++;
        check_field("accepted", want.accepted, got.accepted);
        check_field("sample_count", want.sample_count, got.sample_count);
        check_field("mean_lat_e7", want.mean_lat_e7[LAT_W-1:0], got.mean_lat_e7[LAT_W-1:0]);
        check_field("mean_lon_e7", want.mean_lon_e7[LON_W-1:0], got.mean_lon_e7[LON_W-1:0]);
        check_field("ref_ready", want.ref_ready, got.ref_ready);
        check_field("save_ready", want.save_ready, got.save_ready);
      end
    end
  end

  // fix sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      fix_ch.valid <= 1'b0;
    end else if (took_fix || !fix_ch.valid) begin
      if (gap_left > 0) begin
        gap_left--;
        fix_ch.valid <= 1'b0;
      end else if (pending_fixes.size() > 0) begin
        next_fix = pending_fixes[0];
        fix_ch.valid <= 1'b1;
        fix_ch.fix_valid <= next_fix.fix_valid;
        fix_ch.accuracy_mm <= next_fix.accuracy_mm;
        fix_ch.rx_time_us <= next_fix.rx_time_us;
        fix_ch.lat_e7 <= next_fix.lat_e7;
        fix_ch.lon_e7 <= next_fix.lon_e7;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 9) < 2) begin
            burst_left = $urandom_range(60, 150);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(10, 60);
          end
        end
      end else begin
        fix_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: switches between open, coin-flip and long-stall modes
  always @(negedge clk) begin
    mode_timer++;
    if (mode_timer >= 300) begin
      mode_timer = 0;
      case ($urandom_range(0, 2))
        0: rx_mode = RX_OPEN;
        1: rx_mode = RX_COIN;
        default: rx_mode = RX_STALLS;
      endcase
    end
    if (rst) begin
      rx_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rx_ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: rx_ready = 1'b1;
        RX_COIN: rx_ready = 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(5, 40);
            rx_ready = 1'b0;
          end else begin
            rx_ready = 1'b1;
          end
        end
      endcase
    end
    avg_ch.ready <= rx_ready;
  end

  function automatic fix_t make_fix(input logic v, input logic [ACC_W-1:0] acc,
                                    input logic [TIME_W-1:0] t, input int la, input longint lo);
    fix_t f;
    f.fix_valid = v;
    f.accuracy_mm = acc;
    f.rx_time_us = t;
    f.lat_e7 = la[LAT_W-1:0];
    f.lon_e7 = lo[LON_W-1:0];
    return f;
  endfunction

  function automatic fix_t random_fix();
    fix_t              f;
    int                r;
    int                la;
    longint            lo;
    logic [TIME_W-1:0] t;
    logic [63:0]       wide;
    logic [ACC_W-1:0]  acc;
    wide = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 8) t = prev_time;
    else if (r < 11) t = '0;
    else if (r < 13) t = '1;
    else if (r < 73) t = prev_time + $urandom_range(1, 200000);
    else t = wide[TIME_W-1:0];
    prev_time = t;
    r = $urandom_range(0, 99);
    if (r < 70) acc = $urandom_range(0, acc_limit);
    else if (r < 78) acc = acc_limit;
    else if (r < 84) acc = acc_limit + 1;
    else acc = $urandom;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      la = base_lat + int'($urandom_range(0, 100000)) - 50000;
      lo = base_lon + longint'($urandom_range(0, 100000)) - 50000;
    end else if (r < 80) begin
      la = int'($urandom_range(0, 1800000000)) - 900000000;
      lo = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    end else if (r < 90) begin
      la = $urandom;
      lo = longint'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: begin la = -(1 << 30); lo = -(64'sd1 << 31); end
        1: begin la = (1 << 30) - 1; lo = (64'sd1 << 31) - 1; end
        2: begin la = 900000000; lo = 1800000000; end
        default: begin la = -900000000; lo = -1800000000; end
      endcase
    end
    f = make_fix($urandom_range(0, 99) < 93, acc, t, la, lo);
    return f;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gpma_pkg::REG_MAX_ACCURACY: acc_limit = val;
      gpma_pkg::REG_READY_MIN:    ready_min = val[CNT_W-1:0];
      gpma_pkg::REG_SAVE_MIN:     save_min = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_fixes.size() != 0 || fix_ch.valid || averages_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] acc_lim, input logic [CFG_W-1:0] rdy,
                              input logic [CFG_W-1:0] sav, input int count);
    wait_idle();
    write_reg(gpma_pkg::REG_MAX_ACCURACY, acc_lim);
    write_reg(gpma_pkg::REG_READY_MIN, rdy);
    write_reg(gpma_pkg::REG_SAVE_MIN, sav);
    base_lat = int'($urandom_range(0, 1700000000)) - 850000000;
    base_lon = longint'($urandom_range(0, 32'd3500000000)) - 1750000000;
    for (int i = 0; i < count; i++)
      pending_fixes.push_back(random_fix());
  endtask

  initial begin
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fix_ch.valid = 1'b0;
    fix_ch.fix_valid = 1'b0;
    fix_ch.accuracy_mm = '0;
    fix_ch.rx_time_us = '0;
    fix_ch.lat_e7 = '0;
    fix_ch.lon_e7 = '0;
    avg_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero thresholds on an empty window; all of these are turned away
    write_reg(gpma_pkg::REG_READY_MIN, '0);
    write_reg(gpma_pkg::REG_SAVE_MIN, '0);
    pending_fixes.push_back(make_fix(1'b1, 0, 0, 1, 1));
    pending_fixes.push_back(make_fix(1'b0, 0, 7, 2, 2));
    pending_fixes.push_back(make_fix(1'b1, 5001, 7, 3, 3));
    pending_fixes.push_back(make_fix(1'b1, 32'hFFFF_FFFF, 7, 4, 4));

    wait_idle();
    write_reg(gpma_pkg::REG_READY_MIN, 2);
    write_reg(gpma_pkg::REG_SAVE_MIN, 3);
    pending_fixes.push_back(make_fix(1'b1, 5000, 1, (1 << 30) - 1, (64'sd1 << 31) - 1));
    pending_fixes.push_back(make_fix(1'b1, 0, 1, 5, 5));
    pending_fixes.push_back(make_fix(1'b1, 0, 2, -(1 << 30), -(64'sd1 << 31)));
    pending_fixes.push_back(make_fix(1'b1, 0, 0, -3, -5));
    pending_fixes.push_back(make_fix(1'b1, 0, '1, 900000000, 1800000000));
    pending_fixes.push_back(make_fix(1'b1, 4999, 5, -900000000, -1800000000));
    pending_fixes.push_back(make_fix(1'b1, 0, 5, 7, 7));
    pending_fixes.push_back(make_fix(1'b0, 0, 6, 8, 8));
    pending_fixes.push_back(make_fix(1'b1, 100, 6, -1, -1));

    random_phase(32'hFFFF_FFFF, 512, 511, 700);
    random_phase(0, 0, 512, 250);
    random_phase(gpma_pkg::RESET_MAX_ACCURACY, gpma_pkg::RESET_READY_MIN,
                 gpma_pkg::RESET_SAVE_MIN, 300);
    random_phase($urandom, $urandom_range(0, 512), $urandom_range(0, 512), 350);
    random_phase($urandom_range(1, 100000), 512, 0, 350);

    wait_idle();
    repeat (60) @(posedge clk);
    if (averages_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, averages_due.size());
    end
    $display("%0d fixes over 7 register settings: %0d taken into the window, %0d turned away",
             n_sent, n_taken, n_sent - n_taken);
    $display("%0d results checked, window filled to %0d and wrapped %0d times, %0d errors",
             n_checked, max_fill, n_wraps, errors);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
